// ===== rtl/dxt_pkg.sv =====
`default_nettype none

package dxt_pkg;

    // Format codes held in the configuration register.
    typedef enum logic [1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2,
        FMT_RSVD = 2'd3
    } t_format;

    // Constant divisor applied in the last stage.
    typedef enum logic [1:0] {
        DIV_NONE = 2'd0,
        DIV_3    = 2'd1,
        DIV_5    = 2'd2,
        DIV_7    = 2'd3
    } t_div_sel;

    // Two-bit colour codes.
    localparam logic [1:0] CODE_C0   = 2'd0;
    localparam logic [1:0] CODE_C1   = 2'd1;
    localparam logic [1:0] CODE_MIX0 = 2'd2;
    localparam logic [1:0] CODE_MIX1 = 2'd3;

    // Three-bit alpha codes with fixed meaning.
    localparam logic [2:0] ACODE_A0   = 3'd0;
    localparam logic [2:0] ACODE_A1   = 3'd1;
    localparam logic [2:0] ACODE_ZERO = 3'd6;
    localparam logic [2:0] ACODE_FULL = 3'd7;

    localparam int NUM_W = 11;

    // Reciprocals for exact truncating division of numerators below 2048.
    localparam int SHIFT3 = 11;
    localparam int SHIFT5 = 13;
    localparam int SHIFT7 = 14;
    localparam int RECIP3 = (1 << SHIFT3) / 3 + 1;
    localparam int RECIP5 = (1 << SHIFT5) / 5 + 1;
    localparam int RECIP7 = (1 << SHIFT7) / 7 + 1;

    // Endpoint expansion: v*255/31 = 8v + 7v/31, v*255/63 = 4v + v/21.
    localparam int EXP5_SHIFT = 13;
    localparam int EXP6_SHIFT = 10;
    localparam int EXP5_RECIP = (1 << EXP5_SHIFT) / 31 + 1;
    localparam int EXP6_RECIP = (1 << EXP6_SHIFT) / 21 + 1;

    typedef struct packed {
        logic [63:0] color_block;
        logic [63:0] alpha_block;
        logic [1:0]  texel_x;
        logic [1:0]  texel_y;
    } t_texel_in;

    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_texel_out;

    function automatic logic [7:0] exp5(input logic [4:0] v);
        logic [7:0]  seven_v;
        logic [16:0] prod;
        begin
            seven_v = 8'(v) * 8'd7;
            prod    = 17'(seven_v) * 17'(EXP5_RECIP);
            return {v, 3'b000} + 8'(prod >> EXP5_SHIFT);
        end
    endfunction

    function automatic logic [7:0] exp6(input logic [5:0] v);
        logic [11:0] prod;
        begin
            prod = 12'(v) * 12'(EXP6_RECIP);
            return {v, 2'b00} + 8'(prod >> EXP6_SHIFT);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dxt_recip_div.sv =====
`default_nettype none

module dxt_recip_div (
    input  wire logic [dxt_pkg::NUM_W-1:0] i_num,
    input  wire dxt_pkg::t_div_sel         i_sel,
    output logic [7:0]                     o_quot
);
    import dxt_pkg::*;

    logic [11:0] recip;
    logic [22:0] prod;

    always_comb begin
        unique case (i_sel)
            DIV_3:   recip = 12'(RECIP3);
            DIV_5:   recip = 12'(RECIP5);
            DIV_7:   recip = 12'(RECIP7);
            default: recip = '0;
        endcase
    end

    assign prod = 23'(i_num) * 23'(recip);

    always_comb begin
        unique case (i_sel)
            DIV_3:   o_quot = 8'(prod >> SHIFT3);
            DIV_5:   o_quot = 8'(prod >> SHIFT5);
            DIV_7:   o_quot = 8'(prod >> SHIFT7);
            default: o_quot = i_num[7:0];
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dxt_texel_decoder.sv =====
`default_nettype none
// A result strobe follows each accepted item through the stage-one, stage-two and output registers.
// Throughput: one item per cycle, set by the three-stage pipeline (unpack, numerator, divide).
// busy is always low: the pipeline never stalls because the receiver cannot hold results off.
// Reset (i_rst_n low at a clock edge) clears the format register to DXT1 and drops every
// valid bit in flight; payload registers are not reset.

module dxt_texel_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire dxt_pkg::t_texel_in i_item,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_wdata,
    output logic                    o_valid,
    output dxt_pkg::t_texel_out     o_result
);
    import dxt_pkg::*;

    // Stage one holds the expanded endpoints and the selected codes of the texel.
    typedef struct packed {
        logic [2:0][7:0] p0;
        logic [2:0][7:0] p1;
        logic            four;
        logic [1:0]      code;
        t_format         fmt;
        logic [7:0]      a0;
        logic [7:0]      a1;
        logic [2:0]      k;
        logic [3:0]      nib;
    } t_s1;

    // Stage two holds one numerator and its divisor for each channel, alpha first.
    typedef struct packed {
        logic [3:0][NUM_W-1:0] num;
        t_div_sel [3:0]        sel;
    } t_s2;

    t_format    r_fmt;
    logic       r_v1, r_v2, r_vo;
    t_s1        r_s1, n_s1;
    t_s2        r_s2, n_s2;
    t_texel_out r_out, n_out;
    logic       accept;

    // The pipeline advances every cycle, so the block is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_DXT1;
        end else if (i_cfg_we) begin
            r_fmt <= t_format'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_vo <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_out <= n_out;
    end

    // Stage one: pick out the endpoints, expand them to eight bits and select the
    // texel's colour code and alpha data.
    always_comb begin
        logic [15:0] e0, e1;
        logic [7:0]  row;
        logic [15:0] arow;
        logic [5:0]  apos;
        e0   = i_item.color_block[15:0];
        e1   = i_item.color_block[31:16];
        row  = i_item.color_block[{1'b1, i_item.texel_y, 3'b000} +: 8];
        arow = i_item.alpha_block[{i_item.texel_y, 4'b0000} +: 16];
        apos = 6'd16 + 6'(i_item.texel_y) * 6'd12 + 6'(i_item.texel_x) * 6'd3;

        n_s1.p0[2] = exp5(e0[15:11]);
        n_s1.p0[1] = exp6(e0[10:5]);
        n_s1.p0[0] = exp5(e0[4:0]);
        n_s1.p1[2] = exp5(e1[15:11]);
        n_s1.p1[1] = exp6(e1[10:5]);
        n_s1.p1[0] = exp5(e1[4:0]);
        n_s1.four  = e0 > e1;
        n_s1.code  = row[{i_item.texel_x, 1'b0} +: 2];
        n_s1.fmt   = r_fmt;
        n_s1.a0    = i_item.alpha_block[7:0];
        n_s1.a1    = i_item.alpha_block[15:8];
        n_s1.k     = i_item.alpha_block[apos +: 3];
        n_s1.nib   = arow[{i_item.texel_x, 2'b00} +: 4];
    end

    // Stage two: form each channel's numerator. Colour index 0 is blue, 2 is red.
    always_comb begin
        logic [2:0] c0, c1;
        logic [7:0] pal_alpha;
        for (int i = 0; i < 3; i++) begin
            case (r_s1.code)
                CODE_C0: begin
                    n_s2.num[i] = NUM_W'(r_s1.p0[i]);
                    n_s2.sel[i] = DIV_NONE;
                end
                CODE_C1: begin
                    n_s2.num[i] = NUM_W'(r_s1.p1[i]);
                    n_s2.sel[i] = DIV_NONE;
                end
                CODE_MIX0: begin
                    if (r_s1.four) begin
                        n_s2.num[i] = {r_s1.p0[i], 1'b0} + NUM_W'(r_s1.p1[i]) + 1'b1;
                        n_s2.sel[i] = DIV_3;
                    end else begin
                        n_s2.num[i] = (NUM_W'(r_s1.p0[i]) + NUM_W'(r_s1.p1[i])) >> 1;
                        n_s2.sel[i] = DIV_NONE;
                    end
                end
                default: begin
                    if (r_s1.four) begin
                        n_s2.num[i] = NUM_W'(r_s1.p0[i]) + {r_s1.p1[i], 1'b0} + 1'b1;
                        n_s2.sel[i] = DIV_3;
                    end else begin
                        // Black in three-colour blocks, transparent where alpha comes from the palette.
                        n_s2.num[i] = '0;
                        n_s2.sel[i] = DIV_NONE;
                    end
                end
            endcase
        end

        pal_alpha = (!r_s1.four && r_s1.code == CODE_MIX1) ? 8'd0 : 8'd255;
        c0        = '0;
        c1        = r_s1.k - 3'd1;
        n_s2.sel[3] = DIV_NONE;
        unique case (r_s1.fmt)
            FMT_DXT3: begin
                n_s2.num[3] = NUM_W'({r_s1.nib, r_s1.nib});
            end
            FMT_DXT5: begin
                if (r_s1.k == ACODE_A0) begin
                    n_s2.num[3] = NUM_W'(r_s1.a0);
                end else if (r_s1.k == ACODE_A1) begin
                    n_s2.num[3] = NUM_W'(r_s1.a1);
                end else if (r_s1.a0 > r_s1.a1) begin
                    // Eight-value interpolation in sevenths.
                    c0          = 3'(4'd8 - {1'b0, r_s1.k});
                    n_s2.num[3] = NUM_W'(c0) * NUM_W'(r_s1.a0)
                                + NUM_W'(c1) * NUM_W'(r_s1.a1) + NUM_W'(3);
                    n_s2.sel[3] = DIV_7;
                end else if (r_s1.k == ACODE_ZERO) begin
                    n_s2.num[3] = '0;
                end else if (r_s1.k == ACODE_FULL) begin
                    n_s2.num[3] = NUM_W'(255);
                end else begin
                    // Six-value interpolation in fifths.
                    c0          = 3'(4'd6 - {1'b0, r_s1.k});
                    n_s2.num[3] = NUM_W'(c0) * NUM_W'(r_s1.a0)
                                + NUM_W'(c1) * NUM_W'(r_s1.a1) + NUM_W'(2);
                    n_s2.sel[3] = DIV_5;
                end
            end
            default: begin
                // DXT1 and the reserved code take alpha from the colour palette.
                n_s2.num[3] = NUM_W'(pal_alpha);
            end
        endcase
    end

    // Stage three: one constant divider per channel.
    logic [3:0][7:0] quot;

    for (genvar g = 0; g < 4; g++) begin : g_div
        dxt_recip_div u_div (
            .i_num  (r_s2.num[g]),
            .i_sel  (r_s2.sel[g]),
            .o_quot (quot[g])
        );
    end

    always_comb begin
        n_out.alpha_out = quot[3];
        n_out.red_out   = quot[2];
        n_out.green_out = quot[1];
        n_out.blue_out  = quot[0];
    end

    assign o_valid  = r_vo;
    assign o_result = r_out;

endmodule

`default_nettype wire
